[rtl/core/flrb_pkg.sv]
package flrb_pkg;

    // Default region sizes, in 32-bit words
    localparam int FLASH_WORDS_DEF = 65536;
    localparam int RAM_WORDS_DEF   = 8192;

    // RAM region base byte address
    localparam logic [31:0] RAM_BASE = 32'h2000_0000;

    // Bus action codes
    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_STORE   = 2'd1,
        ACT_PROGRAM = 2'd2
    } t_action;

    // Access size codes; the unused code behaves as a word access
    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } t_size;

    // Byte lanes touched by an access at a given address
    function automatic logic [3:0] lane_enables(input logic [1:0] size,
                                                input logic [1:0] addr_lo);
        logic [3:0] be;
        case (t_size'(size))
            SZ_BYTE: be = 4'b0001 << addr_lo;
            SZ_HALF: be = addr_lo[1] ? 4'b1100 : 4'b0011;
            default: be = 4'b1111;
        endcase
        return be;
    endfunction

    // Right shift, in bits, that brings the addressed lane down to bit 0
    function automatic logic [4:0] lane_shift(input logic [1:0] size,
                                              input logic [1:0] addr_lo);
        logic [4:0] sh;
        case (t_size'(size))
            SZ_BYTE: sh = {addr_lo, 3'b000};
            SZ_HALF: sh = {addr_lo[1], 4'b0000};
            default: sh = 5'd0;
        endcase
        return sh;
    endfunction

endpackage

[rtl/core/flash_ram_bus_with_byte_lanes.sv]
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+-------------------------------------------
// in      | to block  | i_in_valid, o_in_stall | i_action, i_access_size, i_address,
//         |           |                        | i_write_data
// out     | from block| o_out_valid, i_out_stall | o_read_data
//
// One transfer is accepted per cycle while the input does not stall; a load result
// comes from a synchronous memory read, then a lane shift into the output register.
// Stores and program writes complete at the accepting edge and give no result.
// After reset both memories are swept, one word of each per cycle, until every word
// of the larger one is written; the input stalls meanwhile.
// The input stalls while a load result is held in stage 1 behind a stalled output.
module flash_ram_bus_with_byte_lanes #(
    parameter int FLASH_WORDS = flrb_pkg::FLASH_WORDS_DEF,
    parameter int RAM_WORDS   = flrb_pkg::RAM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data
);
    import flrb_pkg::*;

    localparam int FLASH_AW  = $clog2(FLASH_WORDS);
    localparam int RAM_AW    = $clog2(RAM_WORDS);
    localparam int MAX_WORDS = (FLASH_WORDS > RAM_WORDS) ? FLASH_WORDS : RAM_WORDS;
    localparam int CLR_AW    = $clog2(MAX_WORDS);
    localparam logic [31:0] FLASH_BYTES = 32'(FLASH_WORDS * 4);
    localparam logic [31:0] RAM_BYTES   = 32'(RAM_WORDS * 4);

    // Memories
    logic [31:0] r_flash [FLASH_WORDS];
    logic [31:0] r_ram   [RAM_WORDS];
    logic [31:0] r_flash_q;
    logic [31:0] r_ram_q;

    // Control and stage 1
    logic              r_clearing;
    logic [CLR_AW-1:0] r_clr_idx;
    logic              r_s1_valid;
    logic              r_s1_flash;
    logic              r_s1_ram;
    logic [4:0]        r_s1_shift;
    logic [1:0]        r_s1_size;
    logic              r_out_valid;
    logic [31:0]       r_read_data;

    logic              accept;
    logic              advance;
    logic              is_load;
    logic              is_store;
    logic              is_program;
    logic [31:0]       ram_off;
    logic              flash_hit;
    logic              ram_hit;
    logic              prog_hit;
    logic              flash_we;
    logic [FLASH_AW-1:0] flash_widx;
    logic [31:0]       flash_wd;
    logic [3:0]        ram_be;
    logic [RAM_AW-1:0] ram_widx;
    logic [31:0]       ram_wd;
    logic [31:0]       s1_word;
    logic [31:0]       s1_lane;
    logic [31:0]       n_read_data;

    // Handshake
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clearing || (r_s1_valid && !advance);
    assign accept     = i_in_valid && !o_in_stall;

    // Address decode
    assign is_load    = (t_action'(i_action) == ACT_LOAD);
    assign is_store   = (t_action'(i_action) == ACT_STORE);
    assign is_program = (t_action'(i_action) == ACT_PROGRAM);
    assign ram_off    = i_address - RAM_BASE;
    assign flash_hit  = (i_address < FLASH_BYTES);
    assign ram_hit    = (i_address >= RAM_BASE) && (ram_off < RAM_BYTES);
    assign prog_hit   = (i_address < 32'(FLASH_WORDS));

    // Flash write port: clearing sweep or word program
    always_comb begin
        if (r_clearing) begin
            flash_we   = ({1'b0, r_clr_idx} < (CLR_AW+1)'(FLASH_WORDS));
            flash_widx = r_clr_idx[FLASH_AW-1:0];
            flash_wd   = '1;
        end else begin
            flash_we   = accept && is_program && prog_hit;
            flash_widx = i_address[FLASH_AW-1:0];
            flash_wd   = i_write_data;
        end
    end

    // RAM write port: clearing sweep or lane-masked store; data is replicated
    // across lanes so only the enables select the target bytes
    always_comb begin
        if (r_clearing) begin
            ram_be   = ({1'b0, r_clr_idx} < (CLR_AW+1)'(RAM_WORDS)) ? 4'b1111 : 4'b0000;
            ram_widx = r_clr_idx[RAM_AW-1:0];
            ram_wd   = '0;
        end else begin
            ram_be   = (accept && is_store && ram_hit) ?
                       lane_enables(i_access_size, i_address[1:0]) : 4'b0000;
            ram_widx = ram_off[RAM_AW+1:2];
            case (t_size'(i_access_size))
                SZ_BYTE: ram_wd = {4{i_write_data[7:0]}};
                SZ_HALF: ram_wd = {2{i_write_data[15:0]}};
                default: ram_wd = i_write_data;
            endcase
        end
    end

    // Flash array
    always_ff @(posedge i_clk) begin
        if (flash_we) begin
            r_flash[flash_widx] <= flash_wd;
        end
        if (accept && is_load) begin
            r_flash_q <= r_flash[i_address[FLASH_AW+1:2]];
        end
    end

    // RAM array with byte enables
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (ram_be[b]) begin
                r_ram[ram_widx][8*b +: 8] <= ram_wd[8*b +: 8];
            end
        end
        if (accept && is_load) begin
            r_ram_q <= r_ram[ram_off[RAM_AW+1:2]];
        end
    end

    // Clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            if (r_clr_idx == CLR_AW'(MAX_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_idx <= r_clr_idx + CLR_AW'(1);
        end
    end

    // Stage 1: load in flight, memory data arriving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= is_load;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_load) begin
            r_s1_flash <= flash_hit;
            r_s1_ram   <= ram_hit;
            r_s1_shift <= lane_shift(i_access_size, i_address[1:0]);
            r_s1_size  <= i_access_size;
        end
    end

    // Lane extraction
    always_comb begin
        if (r_s1_flash) begin
            s1_word = r_flash_q;
        end else if (r_s1_ram) begin
            s1_word = r_ram_q;
        end else begin
            s1_word = '0;
        end
        case (t_size'(r_s1_size))
            SZ_BYTE: s1_lane = 32'h0000_00FF;
            SZ_HALF: s1_lane = 32'h0000_FFFF;
            default: s1_lane = 32'hFFFF_FFFF;
        endcase
        n_read_data = (s1_word >> r_s1_shift) & s1_lane;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && advance) begin
            r_read_data <= n_read_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

    // Checks
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> o_in_stall)
        else $error("transfer accepted during memory clearing sweep");

    a_no_load_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid && !r_out_valid)
        else $error("load in flight during memory clearing sweep");

    a_out_from_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result presented without a load in stage 1");

    a_stage1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |=> r_s1_valid && $stable(r_s1_shift))
        else $error("stage 1 load lost behind stalled output");

endmodule

[verif/tb_flash_ram_bus_with_byte_lanes.sv]
module tb_flash_ram_bus_with_byte_lanes;
    timeunit 1ns;
    timeprecision 1ps;

    import flrb_pkg::*;

    localparam int FLASH_WORDS = FLASH_WORDS_DEF;
    localparam int RAM_WORDS   = RAM_WORDS_DEF;
    localparam logic [31:0] FLASH_BYTES = 32'(FLASH_WORDS * 4);
    localparam logic [31:0] RAM_BYTES   = 32'(RAM_WORDS * 4);

    // Codes outside the package enums, still legal on the ports
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam logic [1:0] SZ_RESERVED  = 2'd3;

    localparam int RANDOM_ITEMS = 1200;

    // Memory image of both regions plus the loads still in flight
    class lane_bus_model;
        logic [31:0] flash_mem [FLASH_WORDS];
        logic [31:0] ram_mem [RAM_WORDS];
        logic [31:0] load_data_q [$];
        int unsigned mismatches;

        function new();
            foreach (flash_mem[i]) flash_mem[i] = '1;
            foreach (ram_mem[i]) ram_mem[i] = '0;
            mismatches = 0;
        endfunction

        // Word at an aligned byte address; zero outside both regions
        function logic [31:0] lookup_word(logic [31:0] waddr);
            if (waddr < FLASH_BYTES)
                return flash_mem[waddr >> 2];
            if (waddr >= RAM_BASE && (waddr - RAM_BASE) < RAM_BYTES)
                return ram_mem[(waddr - RAM_BASE) >> 2];
            return '0;
        endfunction

        // Apply one accepted transfer; a load queues its expected data
        function void note_transfer(logic [1:0] act, logic [1:0] sz,
                                    logic [31:0] addr, logic [31:0] data);
            logic [31:0] waddr;
            logic [31:0] lane;
            logic [31:0] rel;
            logic [4:0]  shift;
            waddr = {addr[31:2], 2'b00};
            case (sz)
                SZ_BYTE: begin
                    shift = {addr[1:0], 3'b000};
                    lane  = 32'h0000_00FF;
                end
                SZ_HALF: begin
                    shift = {addr[1], 4'b0000};
                    lane  = 32'h0000_FFFF;
                end
                default: begin
                    shift = 5'd0;
                    lane  = 32'hFFFF_FFFF;
                end
            endcase
            case (act)
                ACT_LOAD: begin
                    load_data_q.push_back((lookup_word(waddr) >> shift) & lane);
                end
                ACT_STORE: begin
                    // only RAM takes stores; flash and holes drop them
                    if (waddr >= RAM_BASE && (waddr - RAM_BASE) < RAM_BYTES) begin
                        rel = (waddr - RAM_BASE) >> 2;
                        ram_mem[rel] = (ram_mem[rel] & ~(lane << shift))
                                     | ((data & lane) << shift);
                    end
                end
                ACT_PROGRAM: begin
                    if (addr < 32'(FLASH_WORDS))
                        flash_mem[addr] = data;
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_load(logic [31:0] got);
            logic [31:0] want;
            if (load_data_q.size() == 0) begin
                report_mismatch($sformatf("read_data %h with no load pending", got));
            end else begin
                want = load_data_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("read_data %h, expected %h", got, want));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  action = '0;
    logic [1:0]  access_size = '0;
    logic [31:0] address = '0;
    logic [31:0] write_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] read_data;
    logic [8:0]  stall_phase = '0;

    lane_bus_model model;

    flash_ram_bus_with_byte_lanes dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (action),
        .i_access_size (access_size),
        .i_address     (address),
        .i_write_data  (write_data),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_read_data   (read_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver stall pattern: free-flowing, random, periodic stalls, then random again
    always @(negedge clk) begin
        stall_phase <= stall_phase + 9'd1;
        case (stall_phase[8:7])
            2'd0:    out_stall <= 1'b0;
            2'd1:    out_stall <= ($urandom_range(0, 2) == 0);
            2'd2:    out_stall <= (stall_phase[2:0] < 3'd5);
            default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            model.check_load(read_data);
    end

    // Entered and left at a falling edge; holds the payload until accepted
    task automatic send_access(logic [1:0] act, logic [1:0] sz,
                               logic [31:0] addr, logic [31:0] data);
        in_valid    <= 1'b1;
        action      <= act;
        access_size <= sz;
        address     <= addr;
        write_data  <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        model.note_transfer(act, sz, addr, data);
        @(negedge clk);
    endtask

    task automatic idle_cycles(int unsigned n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (model.load_data_q.size() != 0) @(negedge clk);
    endtask

    initial begin
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        logic [1:0]  act;
        logic [1:0]  sz;
        logic [31:0] addr;
        logic [31:0] data;

        model = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: erased flash, program edges, lanes, misalignment, holes
        send_access(ACT_LOAD,     SZ_WORD,     32'h0000_0000, 32'h0);
        send_access(ACT_PROGRAM,  SZ_WORD,     32'd0,         32'h1122_3344);
        send_access(ACT_PROGRAM,  SZ_BYTE,     32'd65535,     32'hA5A5_5A5A);
        send_access(ACT_PROGRAM,  SZ_WORD,     32'd65536,     32'h0BAD_0BAD);
        send_access(ACT_LOAD,     SZ_BYTE,     32'h0000_0001, 32'h0);
        send_access(ACT_LOAD,     SZ_HALF,     32'h0000_0003, 32'h0);
        send_access(ACT_LOAD,     SZ_WORD,     32'h0003_FFFF, 32'h0);
        send_access(ACT_LOAD,     SZ_WORD,     32'h0004_0000, 32'h0);
        send_access(ACT_STORE,    SZ_WORD,     32'h0000_0000, 32'hFFFF_FFFF);
        send_access(ACT_LOAD,     SZ_WORD,     32'h0000_0003, 32'h0);
        send_access(ACT_STORE,    SZ_WORD,     RAM_BASE,      32'hDEAD_BEEF);
        send_access(ACT_STORE,    SZ_BYTE,     RAM_BASE + 1,  32'hFFFF_FF12);
        send_access(ACT_STORE,    SZ_HALF,     RAM_BASE + 3,  32'hABCD_5678);
        send_access(ACT_LOAD,     SZ_WORD,     RAM_BASE,      32'h0);
        send_access(ACT_STORE,    SZ_RESERVED, 32'h2000_7FFC, 32'hFFFF_FFFF);
        send_access(ACT_LOAD,     SZ_RESERVED, 32'h2000_7FFE, 32'h0);
        send_access(ACT_LOAD,     SZ_BYTE,     32'h2000_7FFF, 32'h0);
        send_access(ACT_STORE,    SZ_WORD,     32'h2000_8000, 32'h1234_5678);
        send_access(ACT_LOAD,     SZ_WORD,     32'h2000_8000, 32'h0);
        send_access(ACT_RESERVED, SZ_WORD,     RAM_BASE,      32'h5555_5555);
        send_access(ACT_LOAD,     SZ_HALF,     RAM_BASE + 2,  32'h0);
        send_access(ACT_LOAD,     SZ_WORD,     32'h1FFF_FFFC, 32'h0);
        send_access(ACT_LOAD,     SZ_BYTE,     32'hFFFF_FFFF, 32'h0);
        drain_results();

        // Random bursts, mostly inside small windows so loads see prior writes
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                pick = $urandom_range(0, 19);
                if (pick < 9)       act = ACT_LOAD;
                else if (pick < 15) act = ACT_STORE;
                else if (pick < 19) act = ACT_PROGRAM;
                else                act = ACT_RESERVED;

                case ($urandom_range(0, 6))
                    0, 1:    sz = SZ_BYTE;
                    2, 3:    sz = SZ_HALF;
                    4, 5:    sz = SZ_WORD;
                    default: sz = SZ_RESERVED;
                endcase

                if (act == ACT_PROGRAM) begin
                    // word index, mostly within the flash window that loads read
                    case ($urandom_range(0, 5))
                        0, 1, 2: addr = $urandom_range(0, 63);
                        3:       addr = $urandom_range(0, FLASH_WORDS - 1);
                        4:       addr = 32'(FLASH_WORDS - 2) + $urandom_range(0, 3);
                        default: addr = $urandom();
                    endcase
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: addr = $urandom_range(0, 255);
                        3:       addr = $urandom_range(0, FLASH_BYTES - 1);
                        4, 5, 6: addr = RAM_BASE + $urandom_range(0, 255);
                        7:       addr = RAM_BASE + $urandom_range(0, RAM_BYTES - 1);
                        8: begin
                            // region boundaries on both sides
                            case ($urandom_range(0, 5))
                                0:       addr = FLASH_BYTES - 4;
                                1:       addr = FLASH_BYTES;
                                2:       addr = RAM_BASE - 4;
                                3:       addr = RAM_BASE + RAM_BYTES - 4;
                                4:       addr = RAM_BASE + RAM_BYTES;
                                default: addr = 32'hFFFF_FFFC;
                            endcase
                            addr = addr + $urandom_range(0, 3);
                        end
                        default: addr = $urandom();
                    endcase
                end

                case ($urandom_range(0, 7))
                    0:       data = 32'h0000_0000;
                    1:       data = 32'hFFFF_FFFF;
                    default: data = $urandom();
                endcase

                send_access(act, sz, addr, data);
                sent++;
                if (sent == RANDOM_ITEMS / 2)
                    drain_results();
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end

        // Let the pipeline empty, then wait for any stray result before reporting
        drain_results();
        repeat (8) @(posedge clk);
        if (model.mismatches == 0) begin
            $display("PASS flash_ram_bus_with_byte_lanes");
        end else begin
            $display("FAIL flash_ram_bus_with_byte_lanes");
        end
        $finish;
    end

    // Watchdog: covers the post-reset sweep plus a slow run many times over
    initial begin
        #5_000_000;
        $display("FAIL flash_ram_bus_with_byte_lanes");
        $finish;
    end

endmodule
